[hdl/cfh_pkg.sv]
// cfh_pkg: shared types, constants and functions of the command CRC-32 hex framer
// holds the queue entry type, ascii codes, trailer phase codes, crc and hex helpers
// no dependencies
package cfh_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [7:0] ASCII_STAR = 8'h2A;
  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A_OFS = 8'h57;

  // trailer sequencer phases
  localparam logic [3:0] PH_BODY      = 4'd0;
  localparam logic [3:0] PH_STAR      = 4'd1;
  localparam logic [3:0] PH_HEX_FIRST = 4'd2;
  localparam logic [3:0] PH_HEX_LAST  = 4'd9;
  localparam logic [3:0] PH_CR        = 4'd10;
  localparam logic [3:0] PH_LF        = 4'd11;

  typedef struct packed {
    logic [31:0] crc;
    logic [7:0]  data;
    logic        present;
    logic        close;
  } entry_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = ASCII_ZERO + {4'd0, n};
    end else begin
      r = ASCII_A_OFS + {4'd0, n};
    end
    return r;
  endfunction

endpackage

[hdl/cfh_front.sv]
// cfh_front: accepts body requests, folds bytes into the running crc, classifies items
// pushes one entry per useful request into the queue, drops idle requests
// depends on cfh_pkg
module cfh_front
  import cfh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_present,
  input  logic       in_close,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [31:0] crc_folded;
  logic        accept;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign crc_folded = in_present ? crc_fold(crc, in_data) : crc;
  assign push       = accept && (in_present || in_close);

  always_comb begin
    crc_next = crc;
    if (accept) begin
      crc_next = in_close ? CRC_INIT : crc_folded;
    end
  end

  always_comb begin
    push_entry.crc     = crc_folded ^ CRC_INIT;
    push_entry.data    = in_data;
    push_entry.present = in_present;
    push_entry.close   = in_close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

[hdl/cfh_queue.sv]
// cfh_queue: short first-in first-out queue of classified entries
// sits between the front and back parts so each can stall on its own
// depends on cfh_pkg
module cfh_queue
  import cfh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_count_bound : assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

[hdl/cfh_back.sv]
// cfh_back: trailer sequencer and output register
// emits any body byte, then '*', eight hex digits, cr and lf for closing entries
// depends on cfh_pkg
module cfh_back
  import cfh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic       out_last
);

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [3:0] eff_phase;
  logic [2:0] nib_idx;
  logic [3:0] nib;
  logic [7:0] byte_sel;
  logic       done;
  logic       load;

  assign eff_phase = (phase == PH_BODY && !head.present) ? PH_STAR : phase;
  assign nib_idx   = 3'(PH_HEX_LAST - eff_phase);
  assign nib       = head.crc[{nib_idx, 2'b00} +: 4];
  assign done      = (eff_phase == PH_LF) || (eff_phase == PH_BODY && !head.close);
  assign load      = !q_empty && (!out_valid || out_ready);
  assign pop       = load && done;

  always_comb begin
    case (eff_phase)
      PH_BODY: byte_sel = head.data;
      PH_STAR: byte_sel = ASCII_STAR;
      PH_CR:   byte_sel = ASCII_CR;
      PH_LF:   byte_sel = ASCII_LF;
      default: byte_sel = hex_char(nib);
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = done ? PH_BODY : eff_phase + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BODY;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= byte_sel;
      out_last <= (eff_phase == PH_LF);
    end
  end

`ifndef SYNTHESIS
  a_last_is_lf : assert property (@(posedge clk) disable iff (rst)
      out_valid && out_last |-> out_data == ASCII_LF)
    else $error("frame end without lf");
  a_phase_range : assert property (@(posedge clk) disable iff (rst) phase <= PH_LF)
    else $error("trailer phase out of range");
  a_mid_trailer_held : assert property (@(posedge clk) disable iff (rst)
      phase != PH_BODY |-> !q_empty)
    else $error("entry left the queue during its trailer");
`endif

endmodule

[hdl/command_crc32_hex_framer_core.sv]
// command_crc32_hex_framer_core: top level of the command crc-32 hex trailer framer
// front (crc, classify) -> queue -> back (trailer sequencer, output register)
// depends on cfh_pkg, cfh_front, cfh_queue, cfh_back
//
// channel  dir  tdata           tuser         tlast
// s_*      in   body_byte[7:0]  byte_present  end_of_body
// m_*      out  out_byte[7:0]   -             frame_last
//
// one request per cycle in unless q_full; one byte per cycle out unless m_tready is low
// a request that closes a body occupies the back sequencer for 11 or 12 output bytes
// s_tready drops only while the queue of QUEUE_DEPTH entries is full
// from request to first output byte: queue write, then output register
// synchronous active-high reset restarts the crc at all ones and empties the queue
module command_crc32_hex_framer_core
  import cfh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // body_byte
  input  logic       s_tuser,  // byte_present
  input  logic       s_tlast,  // end_of_body
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // out_byte
  output logic       m_tlast   // frame_last
);

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;

  cfh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_present (s_tuser),
    .in_close   (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cfh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  cfh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
